@@ rtl/putt_pkg.sv @@
// shared types and constants for the pool usage tracking table
package putt_pkg;

    localparam int SLOTS_DEF = 32;

    // item kinds
    localparam logic [2:0] KIND_CREATE = 3'd0;
    localparam logic [2:0] KIND_DELETE = 3'd1;
    localparam logic [2:0] KIND_ALLOC  = 3'd2;
    localparam logic [2:0] KIND_FREE   = 3'd3;
    localparam logic [2:0] KIND_LIST   = 3'd4;
    localparam logic [2:0] KIND_CLEAR  = 3'd5;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_IGNORED  = 2'd3;

    typedef struct packed {
        logic [31:0] handle;
        logic [31:0] puddle;
        logic [31:0] thresh;
        logic [31:0] count;
        logic [31:0] total;
    } data_t;

    typedef struct packed {
        logic  active;
        data_t data;
    } slot_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] handle;
        logic [31:0] puddle;
        logic [31:0] thresh;
        logic [31:0] size;
        logic        ok;
    } cmd_t;

    // per-cycle controls broadcast to every cell
    typedef struct packed {
        logic capture;
        logic apply;
        logic shift;
        logic clear;
    } ctl_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_APPLY,
        FSM_LIST
    } fsm_t;

endpackage

@@ rtl/putt_cell.sv @@
// one table slot: holds a pool entry, matches handles, takes part in the priority chain
module putt_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  putt_pkg::ctl_t ctl,
    input  putt_pkg::cmd_t cmd,
    input  logic [31:0]    cap_handle,
    input  putt_pkg::slot_t nbr_slot,
    input  logic           chain_in,
    output logic           chain_out,
    output logic           sel,
    output putt_pkg::slot_t slot,
    output putt_pkg::slot_t upd
);
    import putt_pkg::*;

    logic  active_reg, active_next;
    data_t data_reg, data_next;
    logic  match_reg, match_next;
    logic  cand;
    logic [32:0] sum;

    assign slot = '{active: active_reg, data: data_reg};

    // handle compare captured when the item is accepted
    assign match_next = ctl.capture ? (active_reg && (data_reg.handle == cap_handle))
                                    : match_reg;

    // lowest free slot for create, lowest matching slot otherwise
    assign cand      = (cmd.kind == KIND_CREATE) ? !active_reg : match_reg;
    assign sel       = cand && !chain_in;
    assign chain_out = chain_in || cand;

    assign sum = {1'b0, data_reg.total} + {1'b0, cmd.size};

    // updated entry value for the selected slot
    always_comb
    begin
        upd = slot;
        unique case (cmd.kind)
            KIND_CREATE:
            begin
                upd.active      = 1'b1;
                upd.data.handle = cmd.handle;
                upd.data.puddle = cmd.puddle;
                upd.data.thresh = cmd.thresh;
                upd.data.count  = '0;
                upd.data.total  = '0;
            end
            KIND_ALLOC:
            begin
                if (data_reg.count != 32'hFFFF_FFFF)
                    upd.data.count = data_reg.count + 32'd1;
                upd.data.total = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            end
            KIND_FREE:
            begin
                if (data_reg.count != 32'd0)
                    upd.data.count = data_reg.count - 32'd1;
                upd.data.total = (data_reg.total >= cmd.size) ? (data_reg.total - cmd.size)
                                                              : 32'd0;
            end
            default:
            begin
                upd = slot;
            end
        endcase
    end

    // next slot contents: clear, ring shift, or update
    always_comb
    begin
        active_next = active_reg;
        data_next   = data_reg;
        priority if (ctl.clear)
        begin
            active_next = 1'b0;
        end
        else if (ctl.shift)
        begin
            active_next = nbr_slot.active;
            data_next   = nbr_slot.data;
        end
        else if (ctl.apply && sel)
        begin
            if (cmd.kind == KIND_DELETE)
            begin
                active_next = 1'b0;
            end
            else
            begin
                active_next = upd.active;
                data_next   = upd.data;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            match_reg  <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            match_reg  <= match_next;
        end
    end

    // entry payload
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

@@ rtl/pool_usage_tracking_table_top.sv @@
// top level of the pool usage tracking table: command sequencer, cell row, result register
// The table is a row of SLOTS cells, one pool entry per cell. An item is taken
// only while the block is idle. For create, delete, alloc, free, clear and unknown
// kinds the handle compare in every cell is registered at accept; then, once the
// result register is free, a priority chain along the row resolves the lowest free
// or matching cell, which is updated (clear empties every cell instead), and the
// result register is loaded. List then rotates the whole row around its ring one
// cell per cycle while the output is not stalled, reporting each active entry as
// it passes cell 0; after the full turn the row is back in slot order.
// The result register lets the next item be taken while a result waits.
module pool_usage_tracking_table_top #(
    parameter int SLOTS = putt_pkg::SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  kind,
    input  logic [31:0] pool_handle,
    input  logic [31:0] puddle_size,
    input  logic [31:0] thresh_size,
    input  logic [31:0] byte_size,
    input  logic        call_succeeded,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic        entry_valid,
    output logic [31:0] entry_handle,
    output logic [31:0] entry_puddle,
    output logic [31:0] entry_thresh,
    output logic [31:0] entry_count,
    output logic [31:0] entry_total,
    output logic [5:0]  active_slots,
    output logic        last_result
);
    import putt_pkg::*;

    localparam int CW = $clog2(SLOTS + 1);
    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    fsm_t state_reg, state_next;
    cmd_t cmd_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] rem_reg, rem_next;
    logic [IW-1:0] idx_reg, idx_next;
    ctl_t ctl;

    logic accept;
    logic out_free;
    logic found;
    logic [SLOTS:0] chain;
    logic [SLOTS-1:0] sel;
    slot_t slots [SLOTS];
    slot_t upds [SLOTS];
    slot_t sel_upd;

    // result register
    logic        out_valid_reg, out_valid_next;
    logic        load;
    logic [1:0]  res_status;
    slot_t       res_entry;
    logic [CW-1:0] res_count;
    logic        res_last;
    logic [1:0]  status_reg;
    slot_t       entry_reg;
    logic [5:0]  active_reg;
    logic        last_reg;

    assign in_stall = (state_reg != FSM_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // cell row
    assign chain[0] = 1'b0;
    assign found    = chain[SLOTS];

    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        putt_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .cmd        (cmd_reg),
            .cap_handle (pool_handle),
            .nbr_slot   (slots[(i + 1) % SLOTS]),
            .chain_in   (chain[i]),
            .chain_out  (chain[i + 1]),
            .sel        (sel[i]),
            .slot       (slots[i]),
            .upd        (upds[i])
        );
    end

    // pick the updated entry of the selected cell
    always_comb
    begin
        sel_upd = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (sel[i])
                sel_upd = sel_upd | upds[i];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FSM_IDLE:
            begin
                if (accept)
                    state_next = FSM_APPLY;
            end
            FSM_APPLY:
            begin
                if (out_free)
                begin
                    if ((cmd_reg.kind == KIND_LIST) && (count_reg != '0))
                        state_next = FSM_LIST;
                    else
                        state_next = FSM_IDLE;
                end
            end
            FSM_LIST:
            begin
                if (out_free && (idx_reg == IW'(SLOTS - 1)))
                    state_next = FSM_IDLE;
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    // outputs of the sequencer: cell controls, counters and result
    always_comb
    begin
        ctl         = '0;
        ctl.capture = accept;
        count_next  = count_reg;
        rem_next    = rem_reg;
        idx_next    = idx_reg;
        load        = 1'b0;
        res_status  = ST_OK;
        res_entry   = '0;
        res_count   = count_reg;
        res_last    = 1'b1;
        unique case (state_reg)
            FSM_IDLE:
            begin
                idx_next = '0;
                rem_next = count_reg;
            end
            FSM_APPLY:
            begin
                if (out_free)
                begin
                    unique case (cmd_reg.kind)
                        KIND_CREATE:
                        begin
                            load = 1'b1;
                            if (cmd_reg.handle == 32'd0)
                                res_status = ST_IGNORED;
                            else if (found)
                            begin
                                ctl.apply  = 1'b1;
                                res_entry  = sel_upd;
                                count_next = count_reg + CW'(1);
                            end
                            else
                                res_status = ST_FULL;
                        end
                        KIND_DELETE:
                        begin
                            load = 1'b1;
                            if (found)
                            begin
                                ctl.apply  = 1'b1;
                                count_next = count_reg - CW'(1);
                            end
                            else
                                res_status = ST_NOTFOUND;
                        end
                        KIND_ALLOC:
                        begin
                            load = 1'b1;
                            if (!cmd_reg.ok)
                                res_status = ST_IGNORED;
                            else if (found)
                            begin
                                ctl.apply = 1'b1;
                                res_entry = sel_upd;
                            end
                            else
                                res_status = ST_NOTFOUND;
                        end
                        KIND_FREE:
                        begin
                            load = 1'b1;
                            if (found)
                            begin
                                ctl.apply = 1'b1;
                                res_entry = sel_upd;
                            end
                            else
                                res_status = ST_NOTFOUND;
                        end
                        KIND_LIST:
                        begin
                            load = (count_reg == '0);
                        end
                        KIND_CLEAR:
                        begin
                            load       = 1'b1;
                            ctl.clear  = 1'b1;
                            count_next = '0;
                        end
                        default:
                        begin
                            load       = 1'b1;
                            res_status = ST_IGNORED;
                        end
                    endcase
                    res_count = count_next;
                end
            end
            FSM_LIST:
            begin
                if (out_free)
                begin
                    ctl.shift = 1'b1;
                    idx_next  = idx_reg + IW'(1);
                    if (slots[0].active)
                    begin
                        load      = 1'b1;
                        res_entry = slots[0];
                        res_last  = (rem_reg == CW'(1));
                        rem_next  = rem_reg - CW'(1);
                    end
                end
            end
            default:
            begin
                idx_next = '0;
            end
        endcase
    end

    assign out_valid_next = load ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FSM_IDLE;
            count_reg     <= '0;
            rem_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rem_reg       <= rem_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // item and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg.kind   <= kind;
            cmd_reg.handle <= pool_handle;
            cmd_reg.puddle <= puddle_size;
            cmd_reg.thresh <= thresh_size;
            cmd_reg.size   <= byte_size;
            cmd_reg.ok     <= call_succeeded;
        end
        if (load)
        begin
            status_reg <= res_status;
            entry_reg  <= res_entry;
            active_reg <= 6'(res_count);
            last_reg   <= res_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign entry_valid  = entry_reg.active;
    assign entry_handle = entry_reg.data.handle;
    assign entry_puddle = entry_reg.data.puddle;
    assign entry_thresh = entry_reg.data.thresh;
    assign entry_count  = entry_reg.data.count;
    assign entry_total  = entry_reg.data.total;
    assign active_slots = active_reg;
    assign last_result  = last_reg;

endmodule

@@ tb/sv/pool_usage_tracking_table_top_tb.sv @@
// self-checking testbench for the pool usage tracking table top level
module pool_usage_tracking_table_top_tb;

    import putt_pkg::*;

    localparam int SLOTS       = SLOTS_DEF;
    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 300;
    localparam int SIDE_TX     = 0;
    localparam int SIDE_RX     = 1;

    // kinds the block does not define
    localparam logic [2:0] KIND_UNUSED6 = 3'd6;
    localparam logic [2:0] KIND_UNUSED7 = 3'd7;

    typedef struct packed {
        logic [1:0] status;
        logic       valid;
        data_t      entry;
        logic [5:0] active;
        logic       last;
    } pool_result_t;

    // table predictor and queue of pending results
    class pool_scoreboard;
        slot_t        slots[SLOTS];
        pool_result_t expected_q[$];
        int           mismatches;
        int           checked;
        int           full_seen;
        int           kind_seen[8];

        function new();
            wipe();
        endfunction

        function void wipe();
            foreach (slots[i])
                slots[i] = '0;
        endfunction

        function int active_count();
            int n;
            n = 0;
            foreach (slots[i])
                if (slots[i].active)
                    n++;
            return n;
        endfunction

        // lowest active slot holding this handle
        function int find_handle(logic [31:0] h);
            for (int i = 0; i < SLOTS; i++)
                if (slots[i].active && slots[i].data.handle == h)
                    return i;
            return -1;
        endfunction

        function void push_result(logic [1:0] st, int idx, logic last);
            pool_result_t r;
            r.status = st;
            r.valid  = (idx >= 0);
            r.entry  = (idx >= 0) ? slots[idx].data : '0;
            r.active = 6'(active_count());
            r.last   = last;
            expected_q.push_back(r);
        endfunction

        // apply one accepted item to the table and queue its results
        function void note_item(cmd_t c);
            int          idx;
            int          n;
            int          k;
            logic [32:0] sum;
            kind_seen[c.kind]++;
            case (c.kind)
                KIND_CREATE:
                begin
                    idx = -1;
                    for (int i = SLOTS - 1; i >= 0; i--)
                        if (!slots[i].active)
                            idx = i;
                    if (c.handle == '0)
                        push_result(ST_IGNORED, -1, 1'b1);
                    else if (idx < 0)
                    begin
                        full_seen++;
                        push_result(ST_FULL, -1, 1'b1);
                    end
                    else
                    begin
                        slots[idx].active = 1'b1;
                        slots[idx].data   = {c.handle, c.puddle, c.thresh, 64'd0};
                        push_result(ST_OK, idx, 1'b1);
                    end
                end
                KIND_DELETE:
                begin
                    idx = find_handle(c.handle);
                    if (idx < 0)
                        push_result(ST_NOTFOUND, -1, 1'b1);
                    else
                    begin
                        slots[idx] = '0;
                        push_result(ST_OK, -1, 1'b1);
                    end
                end
                KIND_ALLOC:
                begin
                    idx = find_handle(c.handle);
                    if (!c.ok)
                        push_result(ST_IGNORED, -1, 1'b1);
                    else if (idx < 0)
                        push_result(ST_NOTFOUND, -1, 1'b1);
                    else
                    begin
                        // both counters saturate at all ones
                        if (slots[idx].data.count != '1)
                            slots[idx].data.count++;
                        sum = {1'b0, slots[idx].data.total} + {1'b0, c.size};
                        slots[idx].data.total = sum[32] ? '1 : sum[31:0];
                        push_result(ST_OK, idx, 1'b1);
                    end
                end
                KIND_FREE:
                begin
                    idx = find_handle(c.handle);
                    if (idx < 0)
                        push_result(ST_NOTFOUND, -1, 1'b1);
                    else
                    begin
                        // both counters stop at zero
                        if (slots[idx].data.count != '0)
                            slots[idx].data.count--;
                        if (slots[idx].data.total >= c.size)
                            slots[idx].data.total -= c.size;
                        else
                            slots[idx].data.total = '0;
                        push_result(ST_OK, idx, 1'b1);
                    end
                end
                KIND_LIST:
                begin
                    n = active_count();
                    k = 0;
                    if (n == 0)
                        push_result(ST_OK, -1, 1'b1);
                    for (int i = 0; i < SLOTS; i++)
                        if (slots[i].active)
                        begin
                            k++;
                            push_result(ST_OK, i, k == n);
                        end
                end
                KIND_CLEAR:
                begin
                    wipe();
                    push_result(ST_OK, -1, 1'b1);
                end
                default:
                    push_result(ST_IGNORED, -1, 1'b1);
            endcase
        endfunction

        function string show(pool_result_t r);
            return $sformatf("st %0d vld %0b hdl %h pud %h thr %h cnt %h tot %h act %0d last %0b",
                             r.status, r.valid, r.entry.handle, r.entry.puddle, r.entry.thresh,
                             r.entry.count, r.entry.total, r.active, r.last);
        endfunction

        // compare one accepted result with the oldest pending one
        function void check_result(pool_result_t got);
            pool_result_t want;
            checked++;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: %s", show(got));
                return;
            end
            want = expected_q.pop_front();
            if (got.status !== want.status || got.valid !== want.valid ||
                got.entry.handle !== want.entry.handle ||
                got.entry.puddle !== want.entry.puddle ||
                got.entry.thresh !== want.entry.thresh ||
                got.entry.count !== want.entry.count ||
                got.entry.total !== want.entry.total ||
                got.active !== want.active || got.last !== want.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("mismatch on result %0d", checked);
                    $display("  expected: %s", show(want));
                    $display("  actual:   %s", show(got));
                end
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  kind;
    logic [31:0] pool_handle;
    logic [31:0] puddle_size;
    logic [31:0] thresh_size;
    logic [31:0] byte_size;
    logic        call_succeeded;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  status;
    logic        entry_valid;
    logic [31:0] entry_handle;
    logic [31:0] entry_puddle;
    logic [31:0] entry_thresh;
    logic [31:0] entry_count;
    logic [31:0] entry_total;
    logic [5:0]  active_slots;
    logic        last_result;

    pool_scoreboard sb;
    bit             calm[2];
    logic           hold_on;
    int             rx_wait;
    int             cycles;
    logic [31:0]    handle_pool[8];
    event           start_hold;

    pool_usage_tracking_table_top #(
        .SLOTS(SLOTS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .kind(kind),
        .pool_handle(pool_handle),
        .puddle_size(puddle_size),
        .thresh_size(thresh_size),
        .byte_size(byte_size),
        .call_succeeded(call_succeeded),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status(status),
        .entry_valid(entry_valid),
        .entry_handle(entry_handle),
        .entry_puddle(entry_puddle),
        .entry_thresh(entry_thresh),
        .entry_count(entry_count),
        .entry_total(entry_total),
        .active_slots(active_slots),
        .last_result(last_result)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // idle cycles before the next item, with stretches of no idling
    function automatic int draw_gap(int side);
        if ($urandom_range(0, 15) == 0)
            calm[side] = !calm[side];
        return calm[side] ? 0 : $urandom_range(0, 17);
    endfunction

    function automatic cmd_t pool_cmd(logic [2:0] k, logic [31:0] h, logic [31:0] pud,
                                      logic [31:0] thr, logic [31:0] sz, logic ok);
        cmd_t c;
        c.kind   = k;
        c.handle = h;
        c.puddle = pud;
        c.thresh = thr;
        c.size   = sz;
        c.ok     = ok;
        return c;
    endfunction

    // offer one item after a gap and hold it until taken
    task automatic send_item(input cmd_t c, input int gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        kind           <= c.kind;
        pool_handle    <= c.handle;
        puddle_size    <= c.puddle;
        thresh_size    <= c.thresh;
        byte_size      <= c.size;
        call_succeeded <= c.ok;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_item(c);
    endtask

    // stop offering and wait for every pending result
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
    endtask

    // long receiver hold-off, counted here so the sender keeps going
    initial
    begin
        hold_on <= 1'b0;
        forever
        begin
            @(start_hold);
            hold_on <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_on <= 1'b0;
        end
    end

    // result side: take items, check them, draw the next stall
    initial
    begin
        pool_result_t got;
        out_stall <= 1'b0;
        rx_wait = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                got.status       = status;
                got.valid        = entry_valid;
                got.entry.handle = entry_handle;
                got.entry.puddle = entry_puddle;
                got.entry.thresh = entry_thresh;
                got.entry.count  = entry_count;
                got.entry.total  = entry_total;
                got.active       = active_slots;
                got.last         = last_result;
                sb.check_result(got);
                rx_wait = draw_gap(SIDE_RX);
            end
            if (rx_wait > 0)
            begin
                out_stall <= 1'b1;
                rx_wait--;
            end
            else
                out_stall <= hold_on;
        end
    end

    // run limit
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("FAILED: results differ");
        $finish;
    end

    // stimulus
    initial
    begin
        cmd_t        c;
        int          pick;
        int          hpick;
        int          spick;
        logic [31:0] h;
        logic [31:0] sz;
        sb = new();
        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        kind           <= KIND_CREATE;
        pool_handle    <= '0;
        puddle_size    <= '0;
        thresh_size    <= '0;
        byte_size      <= '0;
        call_succeeded <= 1'b0;
        foreach (handle_pool[i])
            handle_pool[i] = $urandom | 32'd1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: corner cases of every kind
        send_item(pool_cmd(KIND_CLEAR, '0, '0, '0, '0, 1'b0), draw_gap(SIDE_TX));
        send_item(pool_cmd(KIND_LIST, '0, '0, '0, '0, 1'b0), draw_gap(SIDE_TX));
        send_item(pool_cmd(KIND_CREATE, '0, '1, '1, '1, 1'b1), draw_gap(SIDE_TX));
        send_item(pool_cmd(KIND_CREATE, '1, '1, '1, '1, 1'b1), draw_gap(SIDE_TX));
        send_item(pool_cmd(KIND_CREATE, 32'd1, '0, '0, '0, 1'b0), draw_gap(SIDE_TX));
        send_item(pool_cmd(KIND_CREATE, 32'd1, 32'd64, 32'd4096, '0, 1'b0), draw_gap(SIDE_TX));
        // total saturates on a second alloc after a large one
        send_item(pool_cmd(KIND_ALLOC, '1, '0, '0, '1, 1'b1), draw_gap(SIDE_TX));
        send_item(pool_cmd(KIND_ALLOC, '1, '0, '0, 32'd5, 1'b1), draw_gap(SIDE_TX));
        send_item(pool_cmd(KIND_ALLOC, 32'd1, '0, '0, 32'd7, 1'b0), draw_gap(SIDE_TX));
        send_item(pool_cmd(KIND_ALLOC, 32'd99, '0, '0, 32'd7, 1'b1), draw_gap(SIDE_TX));
        // free on an empty entry stays at zero
        send_item(pool_cmd(KIND_FREE, 32'd1, '0, '0, 32'd10, 1'b0), draw_gap(SIDE_TX));
        send_item(pool_cmd(KIND_ALLOC, 32'd1, '0, '0, 32'd100, 1'b1), draw_gap(SIDE_TX));
        send_item(pool_cmd(KIND_FREE, 32'd1, '0, '0, 32'd40, 1'b1), draw_gap(SIDE_TX));
        send_item(pool_cmd(KIND_FREE, 32'd77, '0, '0, 32'd40, 1'b1), draw_gap(SIDE_TX));
        send_item(pool_cmd(KIND_LIST, '0, '0, '0, '0, 1'b0), draw_gap(SIDE_TX));
        send_item(pool_cmd(KIND_DELETE, 32'd1, '0, '0, '0, 1'b0), draw_gap(SIDE_TX));
        send_item(pool_cmd(KIND_DELETE, 32'h1234, '0, '0, '0, 1'b0), draw_gap(SIDE_TX));
        send_item(pool_cmd(KIND_UNUSED6, '1, '1, '1, '1, 1'b1), draw_gap(SIDE_TX));
        send_item(pool_cmd(KIND_UNUSED7, '1, '1, '1, '1, 1'b1), draw_gap(SIDE_TX));
        send_item(pool_cmd(KIND_LIST, '1, '1, '1, '1, 1'b1), draw_gap(SIDE_TX));
        send_item(pool_cmd(KIND_CLEAR, '1, '1, '1, '1, 1'b1), draw_gap(SIDE_TX));
        send_item(pool_cmd(KIND_LIST, '0, '0, '0, '0, 1'b0), draw_gap(SIDE_TX));
        wait_drained();

        // fill past capacity while the receiver holds off
        -> start_hold;
        for (int i = 0; i < SLOTS + 2; i++)
            send_item(pool_cmd(KIND_CREATE, handle_pool[i % 8], $urandom, $urandom, '0, 1'b1), 0);
        send_item(pool_cmd(KIND_LIST, '0, '0, '0, '0, 1'b0), 0);
        wait_drained();

        // random mix over a small set of handles
        for (int i = 0; i < 115; i++)
        begin
            if (i == 57)
                wait_drained();
            pick  = $urandom_range(0, 99);
            hpick = $urandom_range(0, 99);
            spick = $urandom_range(0, 99);
            if (hpick < 86)
                h = handle_pool[$urandom_range(0, 7)];
            else if (hpick < 95)
                h = $urandom;
            else
                h = '0;
            if (spick < 70)
                sz = $urandom_range(0, 4096);
            else if (spick < 92)
                sz = $urandom;
            else
                sz = '1;
            c = pool_cmd(KIND_CREATE, h, $urandom, $urandom, sz, $urandom_range(0, 9) != 0);
            if (pick < 28)
                c.kind = KIND_CREATE;
            else if (pick < 40)
                c.kind = KIND_DELETE;
            else if (pick < 64)
                c.kind = KIND_ALLOC;
            else if (pick < 84)
                c.kind = KIND_FREE;
            else if (pick < 91)
                c.kind = KIND_LIST;
            else if (pick < 94)
                c.kind = KIND_CLEAR;
            else
                c.kind = 3'($urandom_range(0, 7));
            send_item(c, draw_gap(SIDE_TX));
        end

        // drain and let any stray result show up
        wait_drained();
        repeat (SLOTS * 4) @(posedge clk);

        $display("sent %0d create, %0d delete, %0d alloc, %0d free, %0d list, %0d clear, %0d other",
                 sb.kind_seen[KIND_CREATE], sb.kind_seen[KIND_DELETE], sb.kind_seen[KIND_ALLOC],
                 sb.kind_seen[KIND_FREE], sb.kind_seen[KIND_LIST], sb.kind_seen[KIND_CLEAR],
                 sb.kind_seen[KIND_UNUSED6] + sb.kind_seen[KIND_UNUSED7]);
        $display("checked %0d results, %0d creates hit a full table, %0d mismatches, %0d missing",
                 sb.checked, sb.full_seen, sb.mismatches, sb.expected_q.size());
        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

@@ files.f @@
rtl/putt_pkg.sv
rtl/putt_cell.sv
rtl/pool_usage_tracking_table_top.sv
tb/sv/pool_usage_tracking_table_top_tb.sv
